// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the windowed pulse statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define WPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The expression must never be true outside reset.
`define WPS_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

// ===== rtl/wps_pkg.sv =====
// Types, widths and micro-operation codes of the windowed pulse statistics block.
package wps_pkg;

  localparam int WINDOW_DEF = 1024;

  localparam int CH_W    = 24;
  localparam int PK_W    = 16;
  localparam int SC_W    = 16;
  localparam int ST_W    = 24;
  localparam int CTOT_W  = 36;
  localparam int PTOT_W  = 28;
  localparam int CSQ_W   = 59;
  localparam int PSQ_W   = 43;
  localparam int MA_W    = 59;
  localparam int MB_W    = 36;
  localparam int PROD_W  = 72;
  localparam int DIV_W   = 40;
  localparam int DVS_W   = 16;
  localparam int RAD_W   = 72;
  localparam int ROOT_W  = 36;
  localparam int SR_W    = ROOT_W + 3;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int SCNT_W  = $clog2(RAD_W / 2 + 1);
  localparam int VAR_SH  = 16;
  localparam int RAM_W   = CH_W + 2 * PK_W;

  typedef enum logic [4:0] {
    OP_CHARGE_DIV,
    OP_READ_OLD,
    OP_SUB_OLD,
    OP_OC2,
    OP_OP2,
    OP_OB2,
    OP_WRITE,
    OP_NC2,
    OP_NP2,
    OP_NB2,
    OP_MEAN_C,
    OP_MEAN_P,
    OP_MEAN_B,
    OP_NS2_C,
    OP_S1SQ_C,
    OP_SQRT_C,
    OP_DEVDIV_C,
    OP_NS2_P,
    OP_S1SQ_P,
    OP_SQRT_P,
    OP_DEVDIV_P,
    OP_NS2_B,
    OP_S1SQ_B,
    OP_SQRT_B,
    OP_DEVDIV_B,
    OP_END
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic commit;
    logic publish;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic rec;
    logic evict;
    logic nonempty;
    logic busy;
  } status_t;

endpackage

// ===== rtl/windowed_pulse_statistics_core.sv =====
// Top level of the sliding-window pulse statistics block.
//
// Input beats carry one pulse event (integral, peak, baseline, clear) on a
// valid/ready channel; each accepted beat yields exactly one output beat with
// the event's charge and the mean and deviation of charge, peak and baseline
// over the window. The charge scale register is written through cfg_we_i.
// An event's processing, from acceptance to its output beat, is shortest with the
// window empty and the event not recorded and longest with a full window dropping
// its oldest entry, and one event is processed at a time. The work is set by the
// shared 40-step restoring divider, which produces up to seven quotients per event,
// the 36-step square root run up to three times, and the shift-add multiplier.
// A finished result sits in an output register, so the next event is accepted
// while it waits; if the receiver stalls, the following result is held until
// the output register frees. Reset empties the window, zeroes all totals and
// sets the scale to one; the window store itself needs no clearing pass.
module windowed_pulse_statistics_core import wps_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  localparam int FW = $clog2(WINDOW + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [SC_W-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [CH_W-1:0] integral_i,
  input  logic [PK_W-1:0] peak_i,
  input  logic [PK_W-1:0] baseline_i,
  input  logic            clear_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CH_W-1:0] charge_o,
  output logic            recorded_o,
  output logic [FW-1:0]   count_o,
  output logic [ST_W-1:0] mean_charge_o,
  output logic [ST_W-1:0] mean_peak_o,
  output logic [ST_W-1:0] mean_baseline_o,
  output logic [ST_W-1:0] std_charge_o,
  output logic [ST_W-1:0] std_peak_o,
  output logic [ST_W-1:0] std_baseline_o
);

  cmd_t    cmd;
  status_t status;

  wps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wps_dp #(
    .WINDOW(WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .integral_i     (integral_i),
    .peak_i         (peak_i),
    .baseline_i     (baseline_i),
    .clear_i        (clear_i),
    .charge_o       (charge_o),
    .recorded_o     (recorded_o),
    .count_o        (count_o),
    .mean_charge_o  (mean_charge_o),
    .mean_peak_o    (mean_peak_o),
    .mean_baseline_o(mean_baseline_o),
    .std_charge_o   (std_charge_o),
    .std_peak_o     (std_peak_o),
    .std_baseline_o (std_baseline_o)
  );

endmodule

// ===== rtl/wps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module wps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/wps_ctrl.sv =====
// Controller that steps through the micro-operations of one pulse event.
module wps_ctrl import wps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  op_e    pc_q, pc_d;
  logic   out_valid_q, out_valid_d;
  logic   op_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= OP_CHARGE_DIV;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    case (pc_q)
      OP_READ_OLD, OP_SUB_OLD, OP_OC2, OP_OP2, OP_OB2: op_en = status_i.evict;
      OP_WRITE, OP_NC2, OP_NP2, OP_NB2:                op_en = status_i.rec;
      OP_CHARGE_DIV, OP_END:                           op_en = 1'b1;
      default:                                         op_en = status_i.nonempty;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    cmd_o       = '0;
    cmd_o.op    = pc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pc_d       = OP_CHARGE_DIV;
          state_d    = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (pc_q == OP_END) begin
          state_d = S_OUT;
        end else if (op_en) begin
          cmd_o.start = 1'b1;
          state_d     = S_WAIT;
        end else begin
          pc_d = op_e'(pc_q + 5'd1);
        end
      end
      S_WAIT: begin
        if (!status_i.busy) begin
          cmd_o.commit = 1'b1;
          pc_d         = op_e'(pc_q + 5'd1);
          state_d      = S_ISSUE;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/wps_dp.sv =====
// Datapath: window store, running totals, shift-add multiplier, divider and square root.
`include "assert_macros.svh"
module wps_dp import wps_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  localparam int AW = $clog2(WINDOW),
  localparam int FW = $clog2(WINDOW + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic              cfg_we_i,
  input  logic [SC_W-1:0]   cfg_wdata_i,
  input  logic [CH_W-1:0]   integral_i,
  input  logic [PK_W-1:0]   peak_i,
  input  logic [PK_W-1:0]   baseline_i,
  input  logic              clear_i,
  output logic [CH_W-1:0]   charge_o,
  output logic              recorded_o,
  output logic [FW-1:0]     count_o,
  output logic [ST_W-1:0]   mean_charge_o,
  output logic [ST_W-1:0]   mean_peak_o,
  output logic [ST_W-1:0]   mean_baseline_o,
  output logic [ST_W-1:0]   std_charge_o,
  output logic [ST_W-1:0]   std_peak_o,
  output logic [ST_W-1:0]   std_baseline_o
);

  function automatic logic [MB_W-1:0] mag(input logic [MB_W-1:0] v);
    return v[MB_W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [SC_W-1:0]   scale_q;
  logic [CH_W-1:0]   integral_q;
  logic [PK_W-1:0]   peak_q, base_q;
  logic              rec_q, evict_q;
  logic [FW-1:0]     fill_q;
  logic [AW-1:0]     oldest_q;
  logic [CTOT_W-1:0] ctot_q;
  logic [PTOT_W-1:0] ptot_q, btot_q;
  logic [CSQ_W-1:0]  csq_q;
  logic [PSQ_W-1:0]  psq_q, bsq_q;
  logic [CH_W-1:0]   charge_q;
  logic [ST_W-1:0]   mean_c_q, mean_p_q, mean_b_q, std_c_q, std_p_q, std_b_q;
  logic [PROD_W-1:0] va_q;
  logic [RAD_W-1:0]  var_q;

  logic [CH_W-1:0]   out_charge_q;
  logic              out_rec_q;
  logic [FW-1:0]     out_count_q;
  logic [ST_W-1:0]   out_mc_q, out_mp_q, out_mb_q, out_sc_q, out_sp_q, out_sb_q;

  logic [PROD_W-1:0] acc_q, ash_q;
  logic [MB_W-1:0]   bsh_q;
  logic              mbusy_q;

  logic [DIV_W-1:0]  dq_q;
  logic [DVS_W-1:0]  drem_q, dd_q;
  logic [DCNT_W-1:0] dcnt_q;

  logic [RAD_W-1:0]  rad_q;
  logic [SR_W-1:0]   srem_q;
  logic [ROOT_W-1:0] root_q;
  logic [SCNT_W-1:0] scnt_q;

  logic [RAM_W-1:0]  rdata;
  logic [CH_W-1:0]   old_c;
  logic [PK_W-1:0]   old_p, old_b;
  logic [MB_W-1:0]   sx_oc, sx_op, sx_ob, sx_nc, sx_np, sx_nb, sx_int, sx_pt, sx_bt;
  logic [MB_W-1:0]   mag_ctot, mag_ptot, mag_btot;
  logic              mul_go, div_go, sqrt_go;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [DIV_W-1:0]  div_n;
  logic [DVS_W-1:0]  div_d;
  logic [DVS_W:0]    d_trial;
  logic              d_ge;
  logic [SR_W-1:0]   s_rem, s_trial;
  logic              s_ge;
  logic [AW:0]       slot_sum, slot_wrap;
  logic [AW-1:0]     slot;
  logic              ram_we, ram_re;
  logic [PROD_W-1:0] diff;
  logic              commit;
  logic              peak_pos;

  assign commit = cmd_i.commit;

  assign old_c = rdata[RAM_W-1 -: CH_W];
  assign old_p = rdata[2*PK_W-1 -: PK_W];
  assign old_b = rdata[PK_W-1:0];

  assign sx_oc  = {{(MB_W-CH_W){old_c[CH_W-1]}}, old_c};
  assign sx_op  = {{(MB_W-PK_W){old_p[PK_W-1]}}, old_p};
  assign sx_ob  = {{(MB_W-PK_W){old_b[PK_W-1]}}, old_b};
  assign sx_nc  = {{(MB_W-CH_W){charge_q[CH_W-1]}}, charge_q};
  assign sx_np  = {{(MB_W-PK_W){peak_q[PK_W-1]}}, peak_q};
  assign sx_nb  = {{(MB_W-PK_W){base_q[PK_W-1]}}, base_q};
  assign sx_int = {{(MB_W-CH_W){integral_q[CH_W-1]}}, integral_q};
  assign sx_pt  = {{(MB_W-PTOT_W){ptot_q[PTOT_W-1]}}, ptot_q};
  assign sx_bt  = {{(MB_W-PTOT_W){btot_q[PTOT_W-1]}}, btot_q};

  assign mag_ctot = mag(ctot_q);
  assign mag_ptot = mag(sx_pt);
  assign mag_btot = mag(sx_bt);

  always_comb begin
    mul_go  = 1'b0;
    div_go  = 1'b0;
    sqrt_go = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_n   = '0;
    div_d   = DVS_W'(fill_q);
    case (cmd_i.op)
      OP_CHARGE_DIV: begin
        div_go = 1'b1;
        div_n  = DIV_W'({mag(sx_int), 8'h00});
        div_d  = (scale_q == '0) ? DVS_W'(1) : scale_q;
      end
      OP_OC2: begin
        mul_go = 1'b1;
        mul_a  = MA_W'(mag(sx_oc));
        mul_b  = mag(sx_oc);
      end
      OP_OP2: begin
        mul_go = 1'b1;
        mul_a  = MA_W'(mag(sx_op));
        mul_b  = mag(sx_op);
      end
      OP_OB2: begin
        mul_go = 1'b1;
        mul_a  = MA_W'(mag(sx_ob));
        mul_b  = mag(sx_ob);
      end
      OP_NC2: begin
        mul_go = 1'b1;
        mul_a  = MA_W'(mag(sx_nc));
        mul_b  = mag(sx_nc);
      end
      OP_NP2: begin
        mul_go = 1'b1;
        mul_a  = MA_W'(mag(sx_np));
        mul_b  = mag(sx_np);
      end
      OP_NB2: begin
        mul_go = 1'b1;
        mul_a  = MA_W'(mag(sx_nb));
        mul_b  = mag(sx_nb);
      end
      OP_MEAN_C: begin
        div_go = 1'b1;
        div_n  = DIV_W'(mag_ctot);
      end
      OP_MEAN_P: begin
        div_go = 1'b1;
        div_n  = DIV_W'({mag_ptot[PTOT_W-1:0], 8'h00});
      end
      OP_MEAN_B: begin
        div_go = 1'b1;
        div_n  = DIV_W'({mag_btot[PTOT_W-1:0], 8'h00});
      end
      OP_NS2_C: begin
        mul_go = 1'b1;
        mul_a  = csq_q;
        mul_b  = MB_W'(fill_q);
      end
      OP_NS2_P: begin
        mul_go = 1'b1;
        mul_a  = MA_W'(psq_q);
        mul_b  = MB_W'(fill_q);
      end
      OP_NS2_B: begin
        mul_go = 1'b1;
        mul_a  = MA_W'(bsq_q);
        mul_b  = MB_W'(fill_q);
      end
      OP_S1SQ_C: begin
        mul_go = 1'b1;
        mul_a  = MA_W'(mag_ctot);
        mul_b  = mag_ctot;
      end
      OP_S1SQ_P: begin
        mul_go = 1'b1;
        mul_a  = MA_W'(mag_ptot);
        mul_b  = mag_ptot;
      end
      OP_S1SQ_B: begin
        mul_go = 1'b1;
        mul_a  = MA_W'(mag_btot);
        mul_b  = mag_btot;
      end
      OP_SQRT_C, OP_SQRT_P, OP_SQRT_B: sqrt_go = 1'b1;
      OP_DEVDIV_C, OP_DEVDIV_P, OP_DEVDIV_B: begin
        div_go = 1'b1;
        div_n  = DIV_W'(root_q);
      end
      default: begin
      end
    endcase
    mul_go  = mul_go && cmd_i.start;
    div_go  = div_go && cmd_i.start;
    sqrt_go = sqrt_go && cmd_i.start;
  end

  // Shift-add multiplier, one multiplier bit per cycle, stops early on zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
    end else if (mul_go) begin
      mbusy_q <= 1'b1;
    end else if (mbusy_q && bsh_q == '0) begin
      mbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_go) begin
      acc_q <= '0;
      ash_q <= PROD_W'(mul_a);
      bsh_q <= mul_b;
    end else if (mbusy_q && bsh_q != '0) begin
      if (bsh_q[0]) begin
        acc_q <= acc_q + ash_q;
      end
      ash_q <= ash_q << 1;
      bsh_q <= bsh_q >> 1;
    end
  end

  // Restoring divider, one quotient bit per cycle.
  assign d_trial = {drem_q, dq_q[DIV_W-1]};
  assign d_ge    = d_trial >= {1'b0, dd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (div_go) begin
      dcnt_q <= DCNT_W'(DIV_W);
    end else if (dcnt_q != '0) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_go) begin
      dq_q   <= div_n;
      drem_q <= '0;
      dd_q   <= div_d;
    end else if (dcnt_q != '0) begin
      drem_q <= d_ge ? DVS_W'(d_trial - {1'b0, dd_q}) : d_trial[DVS_W-1:0];
      dq_q   <= {dq_q[DIV_W-2:0], d_ge};
    end
  end

  // Bit-pair square root, one root bit per cycle.
  assign s_rem   = {srem_q[SR_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign s_trial = SR_W'({root_q, 2'b01});
  assign s_ge    = s_rem >= s_trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q <= '0;
    end else if (sqrt_go) begin
      scnt_q <= SCNT_W'(RAD_W / 2);
    end else if (scnt_q != '0) begin
      scnt_q <= scnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sqrt_go) begin
      rad_q  <= var_q;
      srem_q <= '0;
      root_q <= '0;
    end else if (scnt_q != '0) begin
      rad_q  <= rad_q << 2;
      srem_q <= s_ge ? (s_rem - s_trial) : s_rem;
      root_q <= {root_q[ROOT_W-2:0], s_ge};
    end
  end

  assign slot_sum  = (AW+1)'(oldest_q) + (AW+1)'(fill_q);
  assign slot_wrap = (slot_sum >= (AW+1)'(WINDOW)) ? slot_sum - (AW+1)'(WINDOW) : slot_sum;
  assign slot      = evict_q ? oldest_q : slot_wrap[AW-1:0];
  assign ram_we    = commit && cmd_i.op == OP_WRITE;
  assign ram_re    = cmd_i.start && cmd_i.op == OP_READ_OLD;
  assign diff      = (va_q >= acc_q) ? (va_q - acc_q) : '0;
  assign peak_pos  = !peak_i[PK_W-1] && peak_i != '0;

  wps_ram #(
    .WIDTH(RAM_W),
    .DEPTH(WINDOW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot),
    .wdata_i({charge_q, peak_q, base_q}),
    .re_i   (ram_re),
    .raddr_i(oldest_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SC_W'(1);
      rec_q    <= 1'b0;
      evict_q  <= 1'b0;
      fill_q   <= '0;
      oldest_q <= '0;
      ctot_q   <= '0;
      ptot_q   <= '0;
      btot_q   <= '0;
      csq_q    <= '0;
      psq_q    <= '0;
      bsq_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        rec_q   <= (!clear_i && fill_q != '0) || peak_pos;
        evict_q <= !clear_i && fill_q == FW'(WINDOW);
        if (clear_i) begin
          fill_q   <= '0;
          oldest_q <= '0;
          ctot_q   <= '0;
          ptot_q   <= '0;
          btot_q   <= '0;
          csq_q    <= '0;
          psq_q    <= '0;
          bsq_q    <= '0;
        end
      end else if (commit) begin
        case (cmd_i.op)
          OP_SUB_OLD: begin
            ctot_q <= ctot_q - sx_oc;
            ptot_q <= ptot_q - sx_op[PTOT_W-1:0];
            btot_q <= btot_q - sx_ob[PTOT_W-1:0];
          end
          OP_OC2: csq_q <= csq_q - acc_q[CSQ_W-1:0];
          OP_OP2: psq_q <= psq_q - acc_q[PSQ_W-1:0];
          OP_OB2: bsq_q <= bsq_q - acc_q[PSQ_W-1:0];
          OP_WRITE: begin
            ctot_q <= ctot_q + sx_nc;
            ptot_q <= ptot_q + sx_np[PTOT_W-1:0];
            btot_q <= btot_q + sx_nb[PTOT_W-1:0];
            if (evict_q) begin
              oldest_q <= (oldest_q == AW'(WINDOW - 1)) ? '0 : oldest_q + 1'b1;
            end else begin
              fill_q <= fill_q + 1'b1;
            end
          end
          OP_NC2: csq_q <= csq_q + acc_q[CSQ_W-1:0];
          OP_NP2: psq_q <= psq_q + acc_q[PSQ_W-1:0];
          OP_NB2: bsq_q <= bsq_q + acc_q[PSQ_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      integral_q <= integral_i;
      peak_q     <= peak_i;
      base_q     <= baseline_i;
      mean_c_q   <= '0;
      mean_p_q   <= '0;
      mean_b_q   <= '0;
      std_c_q    <= '0;
      std_p_q    <= '0;
      std_b_q    <= '0;
    end else if (commit) begin
      case (cmd_i.op)
        OP_CHARGE_DIV: begin
          if (!integral_q[CH_W-1]) begin
            charge_q <= (dq_q > DIV_W'(24'h7FFFFF)) ? 24'h7FFFFF : dq_q[CH_W-1:0];
          end else begin
            charge_q <= (dq_q > DIV_W'(24'h800000)) ? 24'h800000 : (~dq_q[CH_W-1:0] + 1'b1);
          end
        end
        OP_MEAN_C: mean_c_q <= ctot_q[CTOT_W-1] ? (~dq_q[ST_W-1:0] + 1'b1) : dq_q[ST_W-1:0];
        OP_MEAN_P: mean_p_q <= ptot_q[PTOT_W-1] ? (~dq_q[ST_W-1:0] + 1'b1) : dq_q[ST_W-1:0];
        OP_MEAN_B: mean_b_q <= btot_q[PTOT_W-1] ? (~dq_q[ST_W-1:0] + 1'b1) : dq_q[ST_W-1:0];
        OP_NS2_C, OP_NS2_P, OP_NS2_B: va_q <= acc_q;
        OP_S1SQ_C: var_q <= diff;
        OP_S1SQ_P, OP_S1SQ_B: var_q <= diff << VAR_SH;
        OP_DEVDIV_C: std_c_q <= (dq_q > DIV_W'(24'hFFFFFF)) ? 24'hFFFFFF : dq_q[ST_W-1:0];
        OP_DEVDIV_P: std_p_q <= (dq_q > DIV_W'(24'hFFFFFF)) ? 24'hFFFFFF : dq_q[ST_W-1:0];
        OP_DEVDIV_B: std_b_q <= (dq_q > DIV_W'(24'hFFFFFF)) ? 24'hFFFFFF : dq_q[ST_W-1:0];
        default: begin
        end
      endcase
    end
    if (cmd_i.publish) begin
      out_charge_q <= charge_q;
      out_rec_q    <= rec_q;
      out_count_q  <= fill_q;
      out_mc_q     <= mean_c_q;
      out_mp_q     <= mean_p_q;
      out_mb_q     <= mean_b_q;
      out_sc_q     <= std_c_q;
      out_sp_q     <= std_p_q;
      out_sb_q     <= std_b_q;
    end
  end

  assign status_o.rec      = rec_q;
  assign status_o.evict    = evict_q;
  assign status_o.nonempty = fill_q != '0;
  assign status_o.busy     = mbusy_q || dcnt_q != '0 || scnt_q != '0;

  assign charge_o        = out_charge_q;
  assign recorded_o      = out_rec_q;
  assign count_o         = out_count_q;
  assign mean_charge_o   = out_mc_q;
  assign mean_peak_o     = out_mp_q;
  assign mean_baseline_o = out_mb_q;
  assign std_charge_o    = out_sc_q;
  assign std_peak_o      = out_sp_q;
  assign std_baseline_o  = out_sb_q;

  `WPS_ASSERT(a_fill_max, fill_q <= FW'(WINDOW), "window count exceeds depth")
  `WPS_ASSERT(a_oldest_range, oldest_q <= AW'(WINDOW - 1), "oldest slot out of range")
  `WPS_ASSERT(a_evict_full, evict_q |-> rec_q && fill_q == FW'(WINDOW), "eviction without full window")
  `WPS_ASSERT_NEVER(a_start_busy, cmd_i.start && status_o.busy, "unit started while busy")

endmodule
